// File: src/wrpe_pkg.sv
// ----------------------------------------------------------------------------
// wrpe_pkg: shared types and constants for the waypoint ring path extractor
// Item layout, register indexes, point sources and pose helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package wrpe_pkg;

    localparam int MAX_WAYPOINTS_DEF = 32;

    localparam int POS_W  = 24;
    localparam int HEAD_W = 16;
    localparam int SLOT_W = 5;
    localparam int CNT_W  = 6;
    localparam int DIST_W = 2 * POS_W + 1;

    localparam logic signed [HEAD_W:0] PI_Q13     = 17'sd25736;
    localparam logic signed [HEAD_W:0] TWO_PI_Q13 = 17'sd51472;

    // Configuration register indexes
    localparam logic CFG_CLOSED_LOOP    = 1'b0;
    localparam logic CFG_WAYPOINT_COUNT = 1'b1;

    // Request kinds
    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_PLAN = 1'b1;

    // Point sources
    localparam logic [1:0] SRC_START    = 2'd0;
    localparam logic [1:0] SRC_WAYPOINT = 2'd1;
    localparam logic [1:0] SRC_GOAL     = 2'd2;

    typedef struct packed {
        logic                     kind;
        logic [SLOT_W-1:0]        slot;
        logic signed [POS_W-1:0]  pos_x;
        logic signed [POS_W-1:0]  pos_y;
        logic signed [HEAD_W-1:0] heading;
        logic signed [POS_W-1:0]  goal_x;
        logic signed [POS_W-1:0]  goal_y;
        logic signed [HEAD_W-1:0] goal_heading;
    } t_item;

    typedef struct packed {
        logic signed [POS_W-1:0]  x;
        logic signed [POS_W-1:0]  y;
        logic signed [HEAD_W-1:0] h;
    } t_wpt;

    // |a - b| for two signed positions; the magnitude always fits POS_W bits
    function automatic logic [POS_W-1:0] abs_diff(input logic signed [POS_W-1:0] a,
                                                  input logic signed [POS_W-1:0] b);
        logic signed [POS_W:0] d;
        logic signed [POS_W:0] nd;
        d  = {a[POS_W-1], a} - {b[POS_W-1], b};
        nd = -d;
        return d[POS_W] ? nd[POS_W-1:0] : d[POS_W-1:0];
    endfunction

    // heading + pi, wrapped into (-pi, pi]
    function automatic logic [HEAD_W-1:0] flip_heading(input logic signed [HEAD_W-1:0] h);
        logic signed [HEAD_W:0] s;
        s = {h[HEAD_W-1], h} + PI_Q13;
        if (s > PI_Q13) begin
            s = s - TWO_PI_Q13;
        end
        return s[HEAD_W-1:0];
    endfunction

endpackage

`default_nettype wire

// File: src/wrpe_front.sv
// ----------------------------------------------------------------------------
// wrpe_front: request intake and two-entry queue
// Drops loads aimed beyond the table, queues the rest for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module wrpe_front #(
    parameter int MAX_WAYPOINTS = wrpe_pkg::MAX_WAYPOINTS_DEF
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    output logic                 o_ready,
    input  wire wrpe_pkg::t_item i_item,
    output logic                 o_q_valid,
    output wrpe_pkg::t_item      o_q_item,
    input  wire logic            i_q_pop
);

    wrpe_pkg::t_item r_buf [2];
    logic            r_wr_ptr;
    logic            r_rd_ptr;
    logic [1:0]      r_count;
    logic            w_acc;
    logic            w_keep;
    logic            w_push;

    assign o_ready = (r_count != 2'd2);
    assign w_acc   = i_valid && o_ready;
    // out-of-range loads are consumed and dropped here
    assign w_keep  = (i_item.kind == wrpe_pkg::KIND_PLAN) ||
                     (32'(i_item.slot) < MAX_WAYPOINTS);
    assign w_push  = w_acc && w_keep;

    assign o_q_valid = (r_count != 2'd0);
    assign o_q_item  = r_buf[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_buf[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_q_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            r_count <= r_count + {1'b0, w_push} - {1'b0, i_q_pop};
        end
    end

    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= 2'd2) else $error("queue overfilled");
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_q_pop |-> r_count != 2'd0) else $error("pop from empty queue");
    a_push_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push && !i_q_pop) |=> r_count == $past(r_count) + 2'd1)
        else $error("push lost");

endmodule

`default_nettype wire

// File: src/wrpe_back.sv
// ----------------------------------------------------------------------------
// wrpe_back: waypoint table, nearest search and path walk
// Pipelined dual nearest scan over the table, then emits the path points.
// ----------------------------------------------------------------------------
`default_nettype none

module wrpe_back #(
    parameter int MAX_WAYPOINTS = wrpe_pkg::MAX_WAYPOINTS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_q_valid,
    input  wire wrpe_pkg::t_item               i_q_item,
    output logic                               o_q_pop,
    input  wire logic                          i_closed_loop,
    input  wire logic [wrpe_pkg::CNT_W-1:0]    i_count,
    output logic                               o_valid,
    input  wire logic                          i_ready,
    output logic signed [wrpe_pkg::POS_W-1:0]  o_x,
    output logic signed [wrpe_pkg::POS_W-1:0]  o_y,
    output logic signed [wrpe_pkg::HEAD_W-1:0] o_h,
    output logic [1:0]                         o_src,
    output logic [wrpe_pkg::SLOT_W-1:0]        o_slot,
    output logic                               o_last
);

    localparam int AW = $clog2(MAX_WAYPOINTS);
    localparam int CW = $clog2(MAX_WAYPOINTS + 1);
    localparam int PW = wrpe_pkg::POS_W;
    localparam int DW = wrpe_pkg::DIST_W;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_SCAN  = 7'b0000010,
        S_DIR   = 7'b0000100,
        S_START = 7'b0001000,
        S_RD    = 7'b0010000,
        S_OUT   = 7'b0100000,
        S_GOAL  = 7'b1000000
    } t_state;

    t_state          r_state, n_state;
    wrpe_pkg::t_wpt  r_mem [MAX_WAYPOINTS];
    wrpe_pkg::t_wpt  r_rd_data;
    wrpe_pkg::t_item r_plan;
    logic [AW-1:0]   w_addr;

    logic [CW-1:0]   r_n;
    logic            r_closed;
    logic [CW-1:0]   r_rd_i;
    logic            r_v1, r_v2, r_v3;
    logic [AW-1:0]   r_i1, r_i2, r_i3;
    logic [PW-1:0]   r_asx, r_asy, r_agx, r_agy;
    logic [2*PW-1:0] r_qsx, r_qsy, r_qgx, r_qgy;
    logic [DW-1:0]   w_ds, w_dg;
    logic [DW-1:0]   r_best_ds, r_best_dg;
    logic [AW-1:0]   r_s, r_g;
    logic [AW-1:0]   r_idx;
    logic            r_fwd;
    logic [CW-1:0]   w_fwd_len, w_bwd_len;
    logic            w_out_free;
    logic            w_issue;
    logic            w_scan_done;

    assign w_out_free  = !o_valid || i_ready;
    assign w_issue     = (r_state == S_SCAN) && (r_rd_i != r_n);
    assign w_scan_done = (r_state == S_SCAN) && (r_rd_i == r_n) && !r_v1 && !r_v2 && !r_v3;
    assign w_addr      = (r_state == S_SCAN) ? r_rd_i[AW-1:0] : r_idx;
    assign o_q_pop     = (r_state == S_IDLE) && i_q_valid;

    assign w_ds = DW'(r_qsx) + DW'(r_qsy);
    assign w_dg = DW'(r_qgx) + DW'(r_qgy);

    assign w_fwd_len = (r_g >= r_s) ? CW'(r_g) - CW'(r_s) : CW'(r_g) + r_n - CW'(r_s);
    assign w_bwd_len = (r_s >= r_g) ? CW'(r_s) - CW'(r_g) : CW'(r_s) + r_n - CW'(r_g);

    // table storage, one write and one registered read
    always_ff @(posedge i_clk) begin
        if (o_q_pop && (i_q_item.kind == wrpe_pkg::KIND_LOAD)) begin
            r_mem[AW'(i_q_item.slot)] <= '{x: i_q_item.pos_x, y: i_q_item.pos_y,
                                           h: i_q_item.heading};
        end
        r_rd_data <= r_mem[w_addr];
    end

    // distance pipeline: diff -> square -> sum/compare
    always_ff @(posedge i_clk) begin
        r_i1  <= r_rd_i[AW-1:0];
        r_i2  <= r_i1;
        r_i3  <= r_i2;
        r_asx <= wrpe_pkg::abs_diff(r_plan.pos_x, r_rd_data.x);
        r_asy <= wrpe_pkg::abs_diff(r_plan.pos_y, r_rd_data.y);
        r_agx <= wrpe_pkg::abs_diff(r_plan.goal_x, r_rd_data.x);
        r_agy <= wrpe_pkg::abs_diff(r_plan.goal_y, r_rd_data.y);
        r_qsx <= (2*PW)'(r_asx) * (2*PW)'(r_asx);
        r_qsy <= (2*PW)'(r_asy) * (2*PW)'(r_asy);
        r_qgx <= (2*PW)'(r_agx) * (2*PW)'(r_agx);
        r_qgy <= (2*PW)'(r_agy) * (2*PW)'(r_agy);
        if (r_v3) begin
            if (r_i3 == '0 || w_ds < r_best_ds) begin
                r_best_ds <= w_ds;
                r_s       <= r_i3;
            end
            if (r_i3 == '0 || w_dg < r_best_dg) begin
                r_best_dg <= w_dg;
                r_g       <= r_i3;
            end
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (o_q_pop && (i_q_item.kind == wrpe_pkg::KIND_PLAN) && (i_count != '0)) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (w_scan_done) begin
                    n_state = S_DIR;
                end
            end
            S_DIR:   n_state = S_START;
            S_START: begin
                if (w_out_free) begin
                    n_state = S_RD;
                end
            end
            S_RD:    n_state = S_OUT;
            S_OUT: begin
                if (w_out_free) begin
                    n_state = (r_idx == r_g) ? S_GOAL : S_RD;
                end
            end
            S_GOAL: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
            r_v3    <= 1'b0;
            o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_v1    <= w_issue;
            r_v2    <= r_v1;
            r_v3    <= r_v2;
            if (w_out_free && (r_state == S_START || r_state == S_OUT ||
                               r_state == S_GOAL)) begin
                o_valid <= 1'b1;
            end else if (i_ready) begin
                o_valid <= 1'b0;
            end
        end
    end

    // plan context and walk control
    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_plan   <= i_q_item;
            r_closed <= i_closed_loop;
            r_n      <= (32'(i_count) > MAX_WAYPOINTS) ? CW'(MAX_WAYPOINTS) : CW'(i_count);
            r_rd_i   <= '0;
        end else if (w_issue) begin
            r_rd_i <= r_rd_i + CW'(1);
        end
        if (r_state == S_DIR) begin
            r_idx <= r_s;
            r_fwd <= r_closed ? (w_fwd_len <= w_bwd_len) : (r_g >= r_s);
        end else if ((r_state == S_OUT) && w_out_free) begin
            if (r_fwd) begin
                r_idx <= (CW'(r_idx) == r_n - CW'(1)) ? '0 : r_idx + AW'(1);
            end else begin
                r_idx <= (r_idx == '0) ? AW'(r_n - CW'(1)) : r_idx - AW'(1);
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (w_out_free) begin
            unique case (r_state)
                S_START: begin
                    o_x    <= r_plan.pos_x;
                    o_y    <= r_plan.pos_y;
                    o_h    <= r_plan.heading;
                    o_src  <= wrpe_pkg::SRC_START;
                    o_slot <= '0;
                    o_last <= 1'b0;
                end
                S_OUT: begin
                    o_x    <= r_rd_data.x;
                    o_y    <= r_rd_data.y;
                    o_h    <= (r_closed && !r_fwd) ? wrpe_pkg::flip_heading(r_rd_data.h)
                                                   : r_rd_data.h;
                    o_src  <= wrpe_pkg::SRC_WAYPOINT;
                    o_slot <= wrpe_pkg::SLOT_W'(r_idx);
                    o_last <= 1'b0;
                end
                S_GOAL: begin
                    o_x    <= r_plan.goal_x;
                    o_y    <= r_plan.goal_y;
                    o_h    <= r_plan.goal_heading;
                    o_src  <= wrpe_pkg::SRC_GOAL;
                    o_slot <= '0;
                    o_last <= 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> r_rd_i <= r_n) else $error("scan overran table");
    a_src_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_src == wrpe_pkg::SRC_START || o_src == wrpe_pkg::SRC_WAYPOINT ||
                     o_src == wrpe_pkg::SRC_GOAL)) else $error("bad point source");
    a_last_goal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last) |-> o_src == wrpe_pkg::SRC_GOAL) else $error("last not goal");
    a_walk_in_table: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT) |-> CW'(r_idx) < r_n) else $error("walk left table");

endmodule

`default_nettype wire

// File: src/waypoint_ring_path_extractor.sv
// ----------------------------------------------------------------------------
// waypoint_ring_path_extractor: nearest-waypoint search and ring path output
// Table-backed planner: loads fill the table, plans emit a point sequence.
// ----------------------------------------------------------------------------
// Usage:
//  - Slave stream takes requests: tuser = kind (0 load, 1 plan). A load writes
//    one table entry and produces nothing; a plan produces start pose, the
//    walked waypoints and the goal pose (tlast on it), or none if count is 0.
//  - Config port (i_cfg_we/index/data) sets closed_loop (index 0) and
//    waypoint_count (index 1); write only while the block is idle.
//  - A front stage classifies requests into a two-entry queue; the back end
//    pops a request once it is idle and runs one at a time. A load is
//    written into the table as it is popped.
//  - A plan runs the pipelined dual nearest scan over the table (one table
//    read per cycle, start and goal compared together), then outputs the
//    start pose, each walked waypoint (table read then output) and the goal;
//    a ring walk over a 32-entry table visits at most 17 waypoints.
//  - Output is registered; a stalled master side holds the point and the
//    walk waits, while the front queue keeps taking requests until full.
//  - Reset clears control state and restores closed_loop=1, count=0. The
//    table contents are undefined until loaded.
// ----------------------------------------------------------------------------
`default_nettype none

module waypoint_ring_path_extractor #(
    parameter int MAX_WAYPOINTS = wrpe_pkg::MAX_WAYPOINTS_DEF
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    // request stream
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // [4:0] slot, [28:5] pos_x, [52:29] pos_y, [68:53] heading,
    // [92:69] goal_x, [116:93] goal_y, [132:117] goal_heading, [135:133] zero
    input  wire logic [135:0] s_axis_tdata,
    input  wire logic         s_axis_tuser,   // [0] kind
    // path point stream
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // [23:0] point_x, [47:24] point_y, [63:48] point_heading,
    // [68:64] point_slot, [71:69] zero
    output logic [71:0]       m_axis_tdata,
    output logic [1:0]        m_axis_tuser,   // [1:0] point_source
    output logic              m_axis_tlast,   // last_point
    // configuration
    input  wire logic         i_cfg_we,
    input  wire logic         i_cfg_index,
    input  wire logic [5:0]   i_cfg_data
);

    wrpe_pkg::t_item                w_in_item;
    wrpe_pkg::t_item                w_q_item;
    logic                           w_q_valid;
    logic                           w_q_pop;
    logic                           r_closed_loop;
    logic [wrpe_pkg::CNT_W-1:0]     r_count;
    logic signed [wrpe_pkg::POS_W-1:0]  w_x, w_y;
    logic signed [wrpe_pkg::HEAD_W-1:0] w_h;
    logic [wrpe_pkg::SLOT_W-1:0]    w_slot;

    assign w_in_item.kind         = s_axis_tuser;
    assign w_in_item.slot         = s_axis_tdata[4:0];
    assign w_in_item.pos_x        = s_axis_tdata[28:5];
    assign w_in_item.pos_y        = s_axis_tdata[52:29];
    assign w_in_item.heading      = s_axis_tdata[68:53];
    assign w_in_item.goal_x       = s_axis_tdata[92:69];
    assign w_in_item.goal_y       = s_axis_tdata[116:93];
    assign w_in_item.goal_heading = s_axis_tdata[132:117];

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_closed_loop <= 1'b1;
            r_count       <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                wrpe_pkg::CFG_CLOSED_LOOP:    r_closed_loop <= i_cfg_data[0];
                wrpe_pkg::CFG_WAYPOINT_COUNT: r_count       <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    wrpe_front #(
        .MAX_WAYPOINTS (MAX_WAYPOINTS)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (s_axis_tvalid),
        .o_ready   (s_axis_tready),
        .i_item    (w_in_item),
        .o_q_valid (w_q_valid),
        .o_q_item  (w_q_item),
        .i_q_pop   (w_q_pop)
    );

    wrpe_back #(
        .MAX_WAYPOINTS (MAX_WAYPOINTS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_valid     (w_q_valid),
        .i_q_item      (w_q_item),
        .o_q_pop       (w_q_pop),
        .i_closed_loop (r_closed_loop),
        .i_count       (r_count),
        .o_valid       (m_axis_tvalid),
        .i_ready       (m_axis_tready),
        .o_x           (w_x),
        .o_y           (w_y),
        .o_h           (w_h),
        .o_src         (m_axis_tuser),
        .o_slot        (w_slot),
        .o_last        (m_axis_tlast)
    );

    assign m_axis_tdata = {3'b000, w_slot, w_h, w_y, w_x};

endmodule

`default_nettype wire

// File: dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the waypoint ring path extractor
// Loads waypoint tables, sends plan requests under random stalls on both
// streams, and checks every path point against an in-bench path predictor.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import wrpe_pkg::*;

    localparam int NWP       = 32;
    localparam int IDLE_LIM  = 20000;
    localparam int TAIL_WAIT = 200;

    typedef struct packed {
        logic [POS_W-1:0]  x;
        logic [POS_W-1:0]  y;
        logic [HEAD_W-1:0] h;
        logic [1:0]        src;
        logic [SLOT_W-1:0] slot;
        logic              last;
    } t_point;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    wire          s_axis_tready;
    logic [135:0] s_axis_tdata = '0;
    logic         s_axis_tuser = 1'b0;
    wire          m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    wire  [71:0]  m_axis_tdata;
    wire  [1:0]   m_axis_tuser;
    wire          m_axis_tlast;
    logic         i_cfg_we = 1'b0;
    logic         i_cfg_index = 1'b0;
    logic [5:0]   i_cfg_data = '0;

    waypoint_ring_path_extractor dut (.*);

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // predictor state: table and registers
    logic signed [POS_W-1:0]  wp_x [NWP];
    logic signed [POS_W-1:0]  wp_y [NWP];
    logic signed [HEAD_W-1:0] wp_h [NWP];
    bit                       loop_mode;
    int                       wp_count;

    t_point path_q[$];
    int     n_fail, n_points, n_plans, n_loads, idle_cycles;
    bit     no_idle;    // final stretch: both sides run flat out

    function automatic void queue_point(input t_point p);
        path_q.insert(path_q.size(), p);
    endfunction

    function automatic longint unsigned dist2(input t_item r, input bit goal, input int i);
        longint ax, ay, dx, dy;
        ax = goal ? longint'(r.goal_x) : longint'(r.pos_x);
        ay = goal ? longint'(r.goal_y) : longint'(r.pos_y);
        dx = ax - longint'(wp_x[i]);
        dy = ay - longint'(wp_y[i]);
        return longint'(dx * dx) + longint'(dy * dy);
    endfunction

    function automatic int nearest_wp(input t_item r, input bit goal, input int n);
        int best;
        longint unsigned bd, d;
        best = 0;
        bd = dist2(r, goal, 0);
        for (int i = 1; i < n; i++) begin
            d = dist2(r, goal, i);
            if (d < bd) begin
                bd = d;
                best = i;
            end
        end
        return best;
    endfunction

    function automatic void queue_wp(input int idx, input bit flip);
        int h;
        h = int'(wp_h[idx]);
        if (flip) begin
            h += 25736;
            if (h > 25736) h -= 51472;
        end
        queue_point('{wp_x[idx], wp_y[idx], h[HEAD_W-1:0], SRC_WAYPOINT, idx[4:0], 1'b0});
    endfunction

    // model one accepted request: table update or expected path points
    function automatic void predict_path(input t_item r);
        int n, s, g, fwd, bwd, idx;
        if (r.kind == KIND_LOAD) begin
            wp_x[r.slot] = r.pos_x;
            wp_y[r.slot] = r.pos_y;
            wp_h[r.slot] = r.heading;
            return;
        end
        n = wp_count > NWP ? NWP : wp_count;
        if (n == 0) return;
        s = nearest_wp(r, 1'b0, n);
        g = nearest_wp(r, 1'b1, n);
        queue_point('{r.pos_x, r.pos_y, r.heading, SRC_START, 5'd0, 1'b0});
        if (loop_mode) begin
            fwd = (g + n - s) % n;
            bwd = (s + n - g) % n;
            if (fwd <= bwd)
                for (int i = 0; i <= fwd; i++) queue_wp((s + i) % n, 1'b0);
            else
                for (int i = 0; i <= bwd; i++) queue_wp((s + n - i) % n, 1'b1);
        end else begin
            idx = s;
            forever begin
                queue_wp(idx, 1'b0);
                if (idx == g) break;
                idx += (g > s) ? 1 : -1;
            end
        end
        queue_point('{r.goal_x, r.goal_y, r.goal_heading, SRC_GOAL, 5'd0, 1'b1});
    endfunction

    // result side: random stalls, field-by-field compare
    always @(posedge i_clk) begin
        t_point got, want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = '{m_axis_tdata[23:0], m_axis_tdata[47:24], m_axis_tdata[63:48],
                    m_axis_tuser, m_axis_tdata[68:64], m_axis_tlast};
            n_points++;
            if (path_q.size() == 0) begin
                $error("unexpected path point %h", got);
                n_fail++;
            end else begin
                want = path_q.pop_front();
                if (got.x != want.x) begin
                    $error("point_x exp %h got %h", want.x, got.x); n_fail++;
                end
                if (got.y != want.y) begin
                    $error("point_y exp %h got %h", want.y, got.y); n_fail++;
                end
                if (got.h != want.h) begin
                    $error("point_heading exp %h got %h", want.h, got.h); n_fail++;
                end
                if (got.src != want.src) begin
                    $error("point_source exp %0d got %0d", want.src, got.src); n_fail++;
                end
                if (got.slot != want.slot) begin
                    $error("point_slot exp %0d got %0d", want.slot, got.slot); n_fail++;
                end
                if (got.last != want.last) begin
                    $error("last_point exp %0b got %0b", want.last, got.last); n_fail++;
                end
            end
        end
    end

    // receiver side: random stall bursts on tready
    int stall_left = 0;
    always @(posedge i_clk) begin
        if (no_idle) begin
            stall_left    <= 0;
            m_axis_tready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left    <= stall_left - 1;
            m_axis_tready <= 1'b0;
        end else if ($urandom_range(0, 5) == 0) begin
            stall_left    <= $urandom_range(0, 2);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // watchdog on cycles with no handshake on either stream
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > IDLE_LIM) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // tvalid stays up after an accept; the next request or a drain takes it over
    task automatic send_request(input t_item r);
        if (!no_idle && $urandom_range(0, 4) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= r.kind;
        s_axis_tdata  <= {3'b0, r.goal_heading, r.goal_y, r.goal_x,
                          r.heading, r.pos_y, r.pos_x, r.slot};
        do @(posedge i_clk); while (!s_axis_tready);
        predict_path(r);
        if (r.kind == KIND_LOAD) n_loads++; else n_plans++;
    endtask

    task automatic drain_path();
        s_axis_tvalid <= 1'b0;
        while (path_q.size() != 0) @(posedge i_clk);
        repeat (TAIL_WAIT) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input int val);
        drain_path();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val[5:0];
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        if (idx == CFG_CLOSED_LOOP) loop_mode = val[0];
        else wp_count = val;
    endtask

    function automatic t_item rand_load(input int slot);
        t_item r;
        logic [159:0] raw;
        raw = {$urandom, $urandom, $urandom, $urandom, $urandom};
        r = raw[$bits(t_item)-1:0];
        r.kind = KIND_LOAD;
        r.slot = slot[4:0];
        r.heading = HEAD_W'(int'($urandom_range(0, 51472)) - 25736);
        return r;
    endfunction

    function automatic t_item rand_plan(input bit near_table);
        t_item r;
        logic [159:0] raw;
        int a, b, n;
        raw = {$urandom, $urandom, $urandom, $urandom, $urandom};
        r = raw[$bits(t_item)-1:0];
        r.kind = KIND_PLAN;
        r.heading      = HEAD_W'(int'($urandom_range(0, 51472)) - 25736);
        r.goal_heading = HEAD_W'(int'($urandom_range(0, 51472)) - 25736);
        n = wp_count > NWP ? NWP : wp_count;
        if (near_table && n > 0) begin
            // poses close to randomly chosen table entries for start and goal
            a = $urandom_range(0, n - 1);
            b = $urandom_range(0, n - 1);
            r.pos_x  = POS_W'(int'(wp_x[a]) + int'($urandom_range(0, 15)) - 8);
            r.pos_y  = wp_y[a];
            r.goal_x = wp_x[b];
            r.goal_y = POS_W'(int'(wp_y[b]) + int'($urandom_range(0, 15)) - 8);
        end
        return r;
    endfunction

    // directed rows: kind, slot, pos x/y/heading, goal x/y/heading
    t_item dir_rows[] = '{
        '{KIND_PLAN, 5'd0, 24'sd0, 24'sd0, 16'sd0, 24'sd5, 24'sd5, 16'sd0},
        '{KIND_LOAD, 5'd0, 24'h7FFFFF, 24'h7FFFFF, 16'sd25736, 24'h0, 24'h0, 16'h0},
        '{KIND_LOAD, 5'd1, 24'h800000, 24'h800000, -16'sd25736, 24'hFFFFFF, 24'h1, 16'h1},
        '{KIND_LOAD, 5'd2, 24'sd0, 24'sd0, 16'sd0, 24'h0, 24'h0, 16'h0},
        '{KIND_LOAD, 5'd3, 24'sd1000, -24'sd1000, 16'sd100, 24'h0, 24'h0, 16'h0},
        '{KIND_LOAD, 5'd31, 24'sd3000, 24'sd3000, -16'sd1, 24'h0, 24'h0, 16'h0},
        // start on extreme corner, goal on other extreme corner
        '{KIND_PLAN, 5'd31, 24'h7FFFFF, 24'h7FFFFF, 16'sd25736,
          24'h800000, 24'h800000, -16'sd25736},
        '{KIND_PLAN, 5'd0, 24'h800000, 24'h7FFFFF, -16'sd25736,
          24'sd1000, -24'sd1000, 16'sd25736},
        // tie: equidistant from slots 2 and 3 -> lower index
        '{KIND_PLAN, 5'd0, 24'sd500, -24'sd500, 16'sd0, 24'sd0, 24'sd0, 16'sd0},
        '{KIND_PLAN, 5'd0, 24'sd1000, -24'sd1000, 16'sd7, 24'sd1, 24'sd1, 16'sd9}
    };

    initial begin
        int phase;
        loop_mode = 1'b1;
        wp_count  = 0;
        no_idle   = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty table plan first (no points), then loads, then 4-entry ring
        foreach (dir_rows[i]) begin
            if (i == 6) write_reg(CFG_WAYPOINT_COUNT, 4);
            send_request(dir_rows[i]);
        end
        write_reg(CFG_CLOSED_LOOP, 0);
        for (int i = 7; i < 10; i++) send_request(dir_rows[i]);
        // load remaining slots so the full table is defined
        for (int s = 4; s < 31; s++) send_request(rand_load(s));
        write_reg(CFG_WAYPOINT_COUNT, 32);
        send_request(rand_plan(1'b1));
        write_reg(CFG_WAYPOINT_COUNT, 63);   // saturates at the table size
        send_request(rand_plan(1'b1));
        write_reg(CFG_CLOSED_LOOP, 1);
        send_request(rand_plan(1'b1));

        // random phases: new count/mode, mostly near-table plans, some reloads
        for (phase = 0; phase < 12; phase++) begin
            write_reg(CFG_CLOSED_LOOP, $urandom_range(0, 1));
            write_reg(CFG_WAYPOINT_COUNT, phase == 11 ? 1 : $urandom_range(1, 8));
            if (phase >= 10) no_idle = 1'b1;
            for (int k = 0; k < 26; k++) begin
                if ($urandom_range(0, 4) == 0)
                    send_request(rand_load($urandom_range(0, 31)));
                else
                    send_request(rand_plan($urandom_range(0, 4) != 0));
                if (k == 13 && phase == 3) drain_path();   // sender holds off
            end
        end

        drain_path();
        $display("Covered %0d loads and %0d plans, %0d path points checked,",
                 n_loads, n_plans, n_points);
        $display("open and closed modes, counts 0 to saturation, random stalls.");
        if (n_fail == 0 && path_q.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

`default_nettype wire
